// ===== sv/wsd_pkg.sv =====
`timescale 1ns / 1ps
package wsd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int TDATA_W     = 88;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAY     = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PAY = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SHORT     = 2'd0,
    ERR_OPCODE    = 2'd1,
    ERR_FRAG_CTRL = 2'd2,
    ERR_CTRL_LEN  = 2'd3
  } err_t;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

  typedef struct packed {
    logic       fin;
    logic [2:0] rsv;
    logic [3:0] opcode;
    logic       mask;
  } hdr_t;

  typedef struct packed {
    kind_t       kind;
    hdr_t        hdr;
    logic [63:0] len;
    logic [7:0]  pbyte;
    err_t        err;
    logic        fend;
  } result_t;

  // one queue entry: a result, optionally followed by a too-short error
  typedef struct packed {
    result_t res;
    logic    extra;
  } entry_t;

  function automatic result_t err_item(err_t code);
    result_t r;
    r       = '0;
    r.kind  = KIND_ERR;
    r.err   = code;
    r.fend  = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// channel | dir | beat content
// s_*     | in  | tdata: data_byte[7:0]; tlast: end_of_buffer
// m_*     | out | tdata: see port; tuser: item_kind; tlast: frame_end
//
// One input beat per cycle while the queue is not full. Parser state updates in
// the cycle of the beat; results pass a small queue and then a registered output
// stage. A beat that yields a result plus a too-short error gives two output
// items, the result first. s_tready drops only when the queue is full. rst is
// synchronous and returns the parser to the first header byte.
module websocket_frame_deframer #(
  parameter int QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // data_byte
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // fin bit, reserved_bits[2:0], frame_opcode[3:0], mask_flag,
  // frame length[63:0], payload_byte[7:0], error_code[1:0], zero pad
  output logic [wsd_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                  m_tuser,  // item_kind
  output logic                        m_tlast
);
  import wsd_pkg::*;

  logic    push, q_full, q_valid, q_pop;
  entry_t  push_entry, q_head;
  result_t res;

  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_eob     (s_tlast),
    .q_full     (q_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  wsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {5'd0, res.err, res.pbyte, res.len, res.hdr.mask,
                    res.hdr.opcode, res.hdr.rsv, res.hdr.fin};
  assign m_tuser = res.kind;
  assign m_tlast = res.fend;

endmodule

// ===== sv/wsd_front.sv =====
`timescale 1ns / 1ps
module wsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_eob,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output wsd_pkg::entry_t push_entry
);
  import wsd_pkg::*;

  phase_t      phase, phase_next;
  hdr_t        hdr, hdr_next;
  logic [63:0] len_acc, len_acc_next;
  logic [3:0]  ext_cnt, ext_cnt_next;
  logic [31:0] key, key_next;
  logic [1:0]  key_idx, key_idx_next;
  logic [63:0] remain, remain_next;

  logic        accept;
  logic        len_done, hdr_done;
  logic [63:0] done_len;
  logic [7:0]  key_byte;
  logic        produce;
  entry_t      entry;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_next   = phase;
    hdr_next     = hdr;
    len_acc_next = len_acc;
    ext_cnt_next = ext_cnt;
    key_next     = key;
    key_idx_next = key_idx;
    remain_next  = remain;
    len_done     = 1'b0;
    hdr_done     = 1'b0;
    done_len     = len_acc;
    key_byte     = 8'd0;
    produce      = 1'b0;
    entry        = '0;

    unique case (phase)
      PH_HDR0: begin
        hdr_next     = '{fin: in_byte[7], rsv: in_byte[6:4], opcode: in_byte[3:0], mask: 1'b0};
        len_acc_next = '0;
        ext_cnt_next = '0;
        key_next     = '0;
        key_idx_next = '0;
        remain_next  = '0;
        if (in_eob) begin
          produce    = 1'b1;
          entry.res  = err_item(ERR_SHORT);
          phase_next = PH_HDR0;
        end else if (in_byte[3:0] inside {[4'd3:4'd7], [4'd11:4'd15]}) begin
          produce    = 1'b1;
          entry.res  = err_item(ERR_OPCODE);
          phase_next = PH_DISCARD;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        hdr_next.mask = in_byte[7];
        if (in_byte[6:0] < LEN_CODE_16) begin
          len_acc_next = {57'd0, in_byte[6:0]};
          done_len     = len_acc_next;
          len_done     = 1'b1;
        end else begin
          ext_cnt_next = (in_byte[6:0] == LEN_CODE_64) ? 4'd8 : 4'd2;
          len_acc_next = '0;
          if (in_eob) begin
            produce    = 1'b1;
            entry.res  = err_item(ERR_SHORT);
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        len_acc_next = {len_acc[55:0], in_byte};
        ext_cnt_next = ext_cnt - 4'd1;
        if (ext_cnt_next == 4'd0) begin
          done_len = len_acc_next;
          len_done = 1'b1;
        end else if (in_eob) begin
          produce    = 1'b1;
          entry.res  = err_item(ERR_SHORT);
          phase_next = PH_HDR0;
        end
      end
      PH_KEY: begin
        key_next     = {key[23:0], in_byte};
        ext_cnt_next = ext_cnt - 4'd1;
        if (ext_cnt_next == 4'd0) begin
          done_len = len_acc;
          hdr_done = 1'b1;
        end else if (in_eob) begin
          produce    = 1'b1;
          entry.res  = err_item(ERR_SHORT);
          phase_next = PH_HDR0;
        end
      end
      PH_PAY: begin
        if (hdr.mask) begin
          case (key_idx)
            2'd0:    key_byte = key[31:24];
            2'd1:    key_byte = key[23:16];
            2'd2:    key_byte = key[15:8];
            default: key_byte = key[7:0];
          endcase
        end
        produce         = 1'b1;
        entry.res.kind  = KIND_PAY;
        entry.res.pbyte = in_byte ^ key_byte;
        entry.res.fend  = (remain <= 64'd1);
        remain_next     = (remain != 64'd0) ? remain - 64'd1 : 64'd0;
        key_idx_next    = key_idx + 2'd1;
        if (remain_next == 64'd0) begin
          phase_next = in_eob ? PH_HDR0 : PH_DISCARD;
        end else if (in_eob) begin
          entry.extra = 1'b1;
          phase_next  = PH_HDR0;
        end
      end
      default: begin
        if (in_eob) begin
          phase_next = PH_HDR0;
        end
      end
    endcase

    // length complete: control checks, then key or header
    if (len_done) begin
      if (hdr_next.opcode[3] && !hdr_next.fin) begin
        produce    = 1'b1;
        entry.res  = err_item(ERR_FRAG_CTRL);
        phase_next = in_eob ? PH_HDR0 : PH_DISCARD;
      end else if (hdr_next.opcode[3] && (done_len > CTRL_MAX_LEN)) begin
        produce    = 1'b1;
        entry.res  = err_item(ERR_CTRL_LEN);
        phase_next = in_eob ? PH_HDR0 : PH_DISCARD;
      end else if (hdr_next.mask) begin
        ext_cnt_next = 4'd4;
        if (in_eob) begin
          produce    = 1'b1;
          entry.res  = err_item(ERR_SHORT);
          phase_next = PH_HDR0;
        end else begin
          phase_next = PH_KEY;
        end
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      produce        = 1'b1;
      entry.res      = '0;
      entry.res.kind = KIND_HDR;
      entry.res.hdr  = hdr_next;
      entry.res.len  = done_len;
      entry.res.fend = (done_len == 64'd0);
      if (done_len == 64'd0) begin
        phase_next = in_eob ? PH_HDR0 : PH_DISCARD;
      end else begin
        remain_next  = done_len;
        key_idx_next = '0;
        phase_next   = PH_PAY;
        if (in_eob) begin
          entry.extra = 1'b1;
          phase_next  = PH_HDR0;
        end
      end
    end
  end

  assign push       = accept && produce;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR0;
      hdr     <= '0;
      len_acc <= '0;
      ext_cnt <= '0;
      key     <= '0;
      key_idx <= '0;
      remain  <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      hdr     <= hdr_next;
      len_acc <= len_acc_next;
      ext_cnt <= ext_cnt_next;
      key     <= key_next;
      key_idx <= key_idx_next;
      remain  <= remain_next;
    end
  end

endmodule

// ===== sv/wsd_queue.sv =====
`timescale 1ns / 1ps
module wsd_queue #(
  parameter int Depth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsd_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output wsd_pkg::entry_t head
);
  import wsd_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  entry_t        slots [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == Full);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== sv/wsd_back.sv =====
`timescale 1ns / 1ps
module wsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  wsd_pkg::entry_t  q_head,
  output logic             q_pop,
  input  logic             out_ready,
  output logic             out_valid,
  output wsd_pkg::result_t out_res
);
  import wsd_pkg::*;

  logic    valid_r, pend_err;
  result_t res_r;
  logic    advance;

  assign advance   = !valid_r || out_ready;
  assign q_pop     = advance && !(valid_r && pend_err) && q_valid;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r  <= 1'b0;
      pend_err <= 1'b0;
    end else if (advance) begin
      if (valid_r && pend_err) begin
        pend_err <= 1'b0;
      end else if (q_valid) begin
        valid_r  <= 1'b1;
        pend_err <= q_head.extra;
      end else begin
        valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (valid_r && pend_err) begin
        res_r <= err_item(ERR_SHORT);
      end else if (q_valid) begin
        res_r <= q_head.res;
      end
    end
  end

endmodule
